### rtl/core/scbp_pkg.sv
`default_nettype none

package scbp_pkg;

   // Size classes and field widths fixed by the request and result formats.
   localparam int SIZE_COUNT = 7;
   localparam int CLASS_W    = 3;
   localparam int SLOT_W     = 13;
   localparam int BYTES_W    = 31;
   localparam int STATUS_W   = 3;
   localparam int PRE_W      = 14;
   localparam int LIMIT_W    = 32;
   localparam int KB_W       = 14;
   localparam int PRE_KB_W   = 28;
   localparam int BUDGET_W   = 33;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;

   typedef logic [SIZE_COUNT-1:0][KB_W-1:0]  class_kb_vec_type;
   typedef logic [SIZE_COUNT-1:0][PRE_W-1:0] prealloc_vec_type;

   // Buffer size of each class in kilobytes, class 0 in the low slot.
   localparam class_kb_vec_type CLASS_KB = {
      14'd8192, 14'd4096, 14'd1024, 14'd256, 14'd64, 14'd16, 14'd4
   };

   localparam logic [LIMIT_W-1:0] MEM_LIMIT_RESET = 32'd5242880;
   localparam prealloc_vec_type PREALLOC_RESET = {
      14'd10, 14'd20, 14'd50, 14'd200, 14'd500, 14'd1000, 14'd5000
   };

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_TOO_LARGE  = 3'd1,
      ST_BUDGET     = 3'd2,
      ST_NO_SLOT    = 3'd3,
      ST_BAD_RETURN = 3'd4
   } status_type;

   typedef enum logic {
      REQ_ALLOC  = 1'b0,
      REQ_RETURN = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      REG_MEM_LIMIT     = 3'd0,
      REG_PREALLOC_4K   = 3'd1,
      REG_PREALLOC_16K  = 3'd2,
      REG_PREALLOC_64K  = 3'd3,
      REG_PREALLOC_256K = 3'd4,
      REG_PREALLOC_1M   = 3'd5,
      REG_PREALLOC_4M   = 3'd6,
      REG_PREALLOC_8M   = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_RETURN,
      CMD_TOO_LARGE,
      CMD_BAD_RETURN
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_RESULT
   } back_state_type;

   typedef struct packed {
      logic               req_type;
      logic [BYTES_W-1:0] request_bytes;
      logic [CLASS_W-1:0] ret_class;
      logic [SLOT_W-1:0]  ret_slot;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CLASS_W-1:0]  size_class;
      logic [SLOT_W-1:0]   slot_id;
   } rsp_item_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [CLASS_W-1:0] cls;
      logic [SLOT_W-1:0]  slot;
   } cmd_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]  mem_limit_kb;
      prealloc_vec_type    prealloc;
      logic [PRE_KB_W-1:0] prealloc_kb;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/core/scbp_csr.sv
`default_nettype none

module scbp_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [scbp_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [scbp_pkg::CSR_DW-1:0]   pwdata,
   output logic      [scbp_pkg::CSR_DW-1:0]   prdata,
   output logic                               pready,
   output scbp_pkg::cfg_type                  cfg
);

   logic [scbp_pkg::LIMIT_W-1:0]  limit_ff, limit_in;
   scbp_pkg::prealloc_vec_type    prealloc_ff, prealloc_in;
   logic [scbp_pkg::PRE_KB_W-1:0] pre_kb_ff, pre_kb_in;
   scbp_pkg::reg_index_type       reg_idx;
   logic                          wr_en;

   assign reg_idx = scbp_pkg::reg_index_type'(paddr[scbp_pkg::CSR_AW-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      limit_in    = limit_ff;
      prealloc_in = prealloc_ff;
      if (wr_en) begin
         unique case (reg_idx)
            scbp_pkg::REG_MEM_LIMIT: limit_in = pwdata;
            default: prealloc_in[3'(reg_idx - 3'd1)] = pwdata[scbp_pkg::PRE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         scbp_pkg::REG_MEM_LIMIT: prdata = limit_ff;
         default: prdata = {{(scbp_pkg::CSR_DW-scbp_pkg::PRE_W){1'b0}},
                            prealloc_ff[3'(reg_idx - 3'd1)]};
      endcase
   end

   // Kilobytes held by all preallocated slots; the class sizes are powers of two.
   always_comb begin
      pre_kb_in = '0;
      for (int c = 0; c < scbp_pkg::SIZE_COUNT; c++) begin
         pre_kb_in = pre_kb_in + scbp_pkg::PRE_KB_W'(prealloc_ff[c])
                               * scbp_pkg::PRE_KB_W'(scbp_pkg::CLASS_KB[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= scbp_pkg::MEM_LIMIT_RESET;
         prealloc_ff <= scbp_pkg::PREALLOC_RESET;
      end else begin
         limit_ff    <= limit_in;
         prealloc_ff <= prealloc_in;
      end
   end

   always_ff @(posedge clock) begin
      pre_kb_ff <= pre_kb_in;
   end

   assign cfg.mem_limit_kb = limit_ff;
   assign cfg.prealloc     = prealloc_ff;
   assign cfg.prealloc_kb  = pre_kb_ff;

endmodule

`default_nettype wire

### rtl/core/scbp_front.sv
`default_nettype none

module scbp_front #(
   parameter int NUM_CLASSES = 7
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  scbp_pkg::req_item_type      req_data,
   output logic                        full,
   output scbp_pkg::cmd_type           cmd,
   output logic                        cmd_empty,
   input  wire logic                   cmd_pop
);

   localparam int LIVE_CLASSES = (NUM_CLASSES < scbp_pkg::SIZE_COUNT) ?
                                 NUM_CLASSES : scbp_pkg::SIZE_COUNT;

   scbp_pkg::cmd_type              cmd_new;
   scbp_pkg::cmd_type              q_ff [2];
   logic [scbp_pkg::CLASS_W-1:0]   found;
   logic                           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                     count_ff, count_in;
   logic                           push_ok;

   // Smallest class whose buffer holds the requested byte count.
   always_comb begin
      found = scbp_pkg::CLASS_W'(scbp_pkg::SIZE_COUNT);
      for (int c = scbp_pkg::SIZE_COUNT - 1; c >= 0; c--) begin
         if ({7'b0, scbp_pkg::CLASS_KB[c], 10'b0} >= req_data.request_bytes) begin
            found = scbp_pkg::CLASS_W'(c);
         end
      end
   end

   always_comb begin
      cmd_new.slot = req_data.ret_slot;
      if (req_data.req_type == scbp_pkg::REQ_RETURN) begin
         cmd_new.cls  = req_data.ret_class;
         cmd_new.kind = (req_data.ret_class >= scbp_pkg::CLASS_W'(LIVE_CLASSES)) ?
                        scbp_pkg::CMD_BAD_RETURN : scbp_pkg::CMD_RETURN;
      end else begin
         cmd_new.cls  = found;
         cmd_new.kind = (found >= scbp_pkg::CLASS_W'(LIVE_CLASSES)) ?
                        scbp_pkg::CMD_TOO_LARGE : scbp_pkg::CMD_ALLOC;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_empty = (count_ff == 2'd0);
   assign push_ok   = push && !full;
   assign cmd       = q_ff[rd_ptr_ff];
   assign count_in  = count_ff + 2'(push_ok) - 2'(cmd_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

### rtl/core/scbp_back.sv
`default_nettype none

module scbp_back #(
   parameter int SLOTS_PER_CLASS = 8192,
   parameter int NUM_CLASSES     = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  scbp_pkg::cfg_type        cfg,
   input  scbp_pkg::cmd_type        cmd,
   input  wire logic                cmd_empty,
   output logic                     cmd_pop,
   output scbp_pkg::rsp_item_type   rsp_data,
   output logic                     empty,
   input  wire logic                pop,
   output logic                     busy
);

   localparam int LIVE_CLASSES = (NUM_CLASSES < scbp_pkg::SIZE_COUNT) ?
                                 NUM_CLASSES : scbp_pkg::SIZE_COUNT;
   localparam int CNT_W     = $clog2(SLOTS_PER_CLASS + 1);
   localparam int MEM_DEPTH = LIVE_CLASSES * SLOTS_PER_CLASS;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int CMP_W     = (CNT_W > scbp_pkg::PRE_W) ? CNT_W : scbp_pkg::PRE_W;
   localparam int SW        = (CNT_W > scbp_pkg::SLOT_W) ? CNT_W : scbp_pkg::SLOT_W;

   logic [scbp_pkg::SLOT_W-1:0]   stack_mem [MEM_DEPTH];
   logic [scbp_pkg::SLOT_W-1:0]   mem_rd_ff;
   logic                          mem_we, mem_re;
   logic [AW-1:0]                 mem_addr, base_addr, push_addr, pop_addr;

   logic [CNT_W-1:0]              depth_ff [scbp_pkg::SIZE_COUNT];
   logic [CNT_W-1:0]              fresh_ff [scbp_pkg::SIZE_COUNT];
   logic [CNT_W-1:0]              cur_depth, cur_fresh, depth_new;
   logic                          depth_we, fresh_we;
   logic [scbp_pkg::LIMIT_W-1:0]  extra_ff, extra_in;

   scbp_pkg::back_state_type      state_ff, state_in;
   scbp_pkg::rsp_item_type        res_ff, res_in, out_item;
   logic                          from_mem_ff, from_mem_in;

   logic [scbp_pkg::KB_W-1:0]     kb;
   logic [CMP_W-1:0]              pre_eff;
   logic [scbp_pkg::BUDGET_W-1:0] budget_total;
   logic                          fresh_lt_pre, over_budget, fresh_full, depth_full;
   logic                          slot_bad;

   scbp_pkg::rsp_item_type        out_q_ff [2];
   logic                          out_wr_ff, out_rd_ff;
   logic [1:0]                    out_count_ff, out_count_in;
   logic                          out_push, out_pop;

   assign cur_depth = depth_ff[cmd.cls];
   assign cur_fresh = fresh_ff[cmd.cls];
   assign kb        = scbp_pkg::CLASS_KB[cmd.cls];

   assign pre_eff = (CMP_W'(cfg.prealloc[cmd.cls]) > CMP_W'(SLOTS_PER_CLASS)) ?
                    CMP_W'(SLOTS_PER_CLASS) : CMP_W'(cfg.prealloc[cmd.cls]);
   assign fresh_lt_pre = CMP_W'(cur_fresh) < pre_eff;
   assign budget_total = scbp_pkg::BUDGET_W'(cfg.prealloc_kb)
                       + scbp_pkg::BUDGET_W'(extra_ff)
                       + scbp_pkg::BUDGET_W'(kb);
   assign over_budget  = budget_total >= scbp_pkg::BUDGET_W'(cfg.mem_limit_kb);
   assign fresh_full   = cur_fresh >= CNT_W'(SLOTS_PER_CLASS);
   assign depth_full   = cur_depth >= CNT_W'(SLOTS_PER_CLASS);
   assign slot_bad     = SW'(cmd.slot) >= SW'(cur_fresh);

   assign base_addr = AW'(cmd.cls) * AW'(SLOTS_PER_CLASS);
   assign push_addr = base_addr + AW'(cur_depth);
   assign pop_addr  = base_addr + AW'(cur_depth - CNT_W'(1));

   always_comb begin
      state_in    = state_ff;
      cmd_pop     = 1'b0;
      out_push    = 1'b0;
      res_in      = res_ff;
      from_mem_in = from_mem_ff;
      depth_we    = 1'b0;
      depth_new   = cur_depth;
      fresh_we    = 1'b0;
      extra_in    = extra_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = push_addr;
      unique case (state_ff)
         scbp_pkg::BK_IDLE: begin
            if (!cmd_empty && out_count_ff != 2'd2) begin
               cmd_pop            = 1'b1;
               state_in           = scbp_pkg::BK_RESULT;
               res_in.status      = scbp_pkg::ST_OK;
               res_in.size_class  = '0;
               res_in.slot_id     = '0;
               from_mem_in        = 1'b0;
               unique case (cmd.kind)
                  scbp_pkg::CMD_RETURN: begin
                     if (slot_bad || depth_full) begin
                        res_in.status = scbp_pkg::ST_BAD_RETURN;
                     end else begin
                        mem_we    = 1'b1;
                        mem_addr  = push_addr;
                        depth_we  = 1'b1;
                        depth_new = cur_depth + CNT_W'(1);
                     end
                  end
                  scbp_pkg::CMD_ALLOC: begin
                     if (cur_depth != '0) begin
                        // Most recently returned slot; the id arrives from memory.
                        depth_we          = 1'b1;
                        depth_new         = cur_depth - CNT_W'(1);
                        mem_re            = 1'b1;
                        mem_addr          = pop_addr;
                        res_in.size_class = cmd.cls;
                        from_mem_in       = 1'b1;
                     end else if (fresh_lt_pre) begin
                        fresh_we          = 1'b1;
                        res_in.size_class = cmd.cls;
                        res_in.slot_id    = scbp_pkg::SLOT_W'(cur_fresh);
                     end else if (over_budget) begin
                        res_in.status = scbp_pkg::ST_BUDGET;
                     end else if (fresh_full) begin
                        res_in.status = scbp_pkg::ST_NO_SLOT;
                     end else begin
                        extra_in          = extra_ff + scbp_pkg::LIMIT_W'(kb);
                        fresh_we          = 1'b1;
                        res_in.size_class = cmd.cls;
                        res_in.slot_id    = scbp_pkg::SLOT_W'(cur_fresh);
                     end
                  end
                  scbp_pkg::CMD_TOO_LARGE: begin
                     res_in.status = scbp_pkg::ST_TOO_LARGE;
                  end
                  scbp_pkg::CMD_BAD_RETURN: begin
                     res_in.status = scbp_pkg::ST_BAD_RETURN;
                  end
               endcase
            end
         end
         scbp_pkg::BK_RESULT: begin
            out_push = 1'b1;
            state_in = scbp_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scbp_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < scbp_pkg::SIZE_COUNT; c++) begin
            depth_ff[c] <= '0;
            fresh_ff[c] <= '0;
         end
         extra_ff <= '0;
      end else begin
         if (depth_we) begin
            depth_ff[cmd.cls] <= depth_new;
         end
         if (fresh_we) begin
            fresh_ff[cmd.cls] <= cur_fresh + CNT_W'(1);
         end
         extra_ff <= extra_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      from_mem_ff <= from_mem_in;
   end

   // Per-class LIFO stacks of returned slot ids, one region per class.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_addr] <= cmd.slot;
      end
      if (mem_re) begin
         mem_rd_ff <= stack_mem[mem_addr];
      end
   end

   always_comb begin
      out_item = res_ff;
      if (from_mem_ff) begin
         out_item.slot_id = mem_rd_ff;
      end
   end

   assign empty        = (out_count_ff == 2'd0);
   assign out_pop      = pop && !empty;
   assign rsp_data     = out_q_ff[out_rd_ff];
   assign out_count_in = out_count_ff + 2'(out_push) - 2'(out_pop);
   assign busy         = (state_ff != scbp_pkg::BK_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         if (out_push) begin
            out_wr_ff <= !out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= !out_rd_ff;
         end
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_q_ff[out_wr_ff] <= out_item;
      end
   end

endmodule

`default_nettype wire

### rtl/core/size_class_buffer_pool.sv
// Buffer pool with seven size classes (4K to 8M bytes) that hands out slot ids.
// Requests enter through a queue-like port: a transaction is taken on a clock
// edge where push is high and full is low. An allocate maps request_bytes to
// the smallest class that fits and grants a returned slot, a fresh
// preallocated slot, or an extra slot charged against the kilobyte budget.
// A return pushes the slot id back on its class stack.
// Results leave the same way: while empty is low the oldest result sits on
// rsp_data and is taken on an edge where pop is high.
// The front end classifies each request and parks it in a two-entry command
// queue; the back end executes one command at a time and takes no new one
// until it has pushed the last result: stack memory read data and counter
// updates are registered at the same edge, and the result is then written
// into the result queue. On an idle block a request passes the command queue
// and the result registers before empty goes low. A stalled receiver fills
// the two-entry result queue, then the command queue, after which full rises;
// nothing is dropped.
// Synchronous reset clears all counters, the budget charge and both queues and
// restores the register defaults. The stack memory needs no clearing pass and
// the block accepts requests in the first cycle after reset.
// Registers are written through the APB port at byte address 4*index.
`default_nettype none

module size_class_buffer_pool #(
   parameter int SLOTS_PER_CLASS = 8192,
   parameter int NUM_CLASSES     = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  scbp_pkg::req_item_type             req_data,
   output logic                               full,
   output logic                               empty,
   input  wire logic                          pop,
   output scbp_pkg::rsp_item_type             rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [scbp_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [scbp_pkg::CSR_DW-1:0]   pwdata,
   output logic      [scbp_pkg::CSR_DW-1:0]   prdata,
   output logic                               pready
);

   scbp_pkg::cfg_type cfg;
   scbp_pkg::cmd_type cmd;
   logic              cmd_empty;
   logic              cmd_pop;
   logic              back_busy;

   // Configuration registers and the preallocated kilobyte total.
   scbp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Classifier and command queue.
   scbp_front #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop)
   );

   // Slot bookkeeping, stack memory and result queue.
   scbp_back #(
      .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
      .NUM_CLASSES     (NUM_CLASSES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_data),
      .empty     (empty),
      .pop       (pop),
      .busy      (back_busy)
   );

`ifndef SYNTHESIS
   // Only a successful allocate carries a class and slot id.
   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.status != scbp_pkg::ST_OK
      |-> rsp_data.size_class == '0 && rsp_data.slot_id == '0)
      else $error("failed result carries a nonzero class or slot id");

   // Both queues come out of reset empty.
   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   // On an idle block an accepted request leaves its result waiting in the result queue.
   assert property (@(posedge clock) disable iff (reset)
      push && !full && empty && cmd_empty && !back_busy |-> ##3 !empty)
      else $error("result missing three cycles after request on idle block");
`endif

endmodule

`default_nettype wire

### tb/tb_size_class_buffer_pool.sv
`default_nettype none

module tb_size_class_buffer_pool;
   timeunit 1ns;
   timeprecision 1ps;

   import scbp_pkg::*;

   // The block is built with its default geometry: 8192 slot ids per class.
   localparam int SLOTS_PER_CLASS = 8192;
   // Longest run of cycles with no transaction on either side before the run
   // is declared hung. The long receiver hold-off below is much shorter.
   localparam int QUIET_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   // Cycles to keep watching after the last result.
   localparam int DRAIN_CYCLES    = 20;

   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      logic [SLOT_W-1:0]  slot;
   } buffer_ref_type;

   typedef struct packed {
      logic         from_alloc;
      rsp_item_type rsp;
   } awaited_result_type;

   logic                clock   = 1'b0;
   logic                reset   = 1'b1;
   logic                push    = 1'b0;
   req_item_type        req_data = '0;
   logic                full;
   logic                empty;
   logic                pop     = 1'b0;
   rsp_item_type        rsp_data;
   logic                psel    = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite  = 1'b0;
   logic [CSR_AW-1:0]   paddr   = '0;
   logic [CSR_DW-1:0]   pwdata  = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   size_class_buffer_pool dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // ---------------------------------------------------------------------
   // Shadow of the pool. The per-class LIFO stacks, the stack depths, the
   // count of slot ids handed out so far, the extra kilobytes charged and
   // the register values are all kept here; all but the register values
   // advance once per accepted request transaction.
   // ---------------------------------------------------------------------
   logic [SLOT_W-1:0]  free_slots [SIZE_COUNT][SLOTS_PER_CLASS];
   int unsigned        stack_top [SIZE_COUNT];
   int unsigned        fresh_count [SIZE_COUNT];
   longint unsigned    extra_kb;
   logic [LIMIT_W-1:0] limit_kb;
   logic [PRE_W-1:0]   prealloc_cfg [SIZE_COUNT];

   // Request transactions waiting to be offered, results predicted but not
   // yet seen, and buffers granted so far that the stimulus may hand back.
   req_item_type       pending_requests [$];
   awaited_result_type awaited_results [$];
   buffer_ref_type     outstanding_buffers [$];
   awaited_result_type head;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int rx_hold_left   = 0;
   int quiet_cycles   = 0;
   int error_count    = 0;
   int results_seen   = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Memory charged against the budget: every preallocated slot at the
   // current register values, whether used or not, plus the extra slots.
   function automatic longint unsigned booked_kb();
      longint unsigned sum;
      sum = extra_kb;
      for (int k = 0; k < SIZE_COUNT; k++)
         sum += 64'(prealloc_cfg[k]) * 64'(CLASS_KB[k]);
      return sum;
   endfunction

   // Applies one request to the shadow pool and returns the result the
   // block has to produce for it.
   function automatic rsp_item_type serve_request(input req_item_type r);
      rsp_item_type res;
      int           cls;
      int unsigned  slot;
      int unsigned  usable_prealloc;
      logic         granted;
      res        = '0;
      res.status = ST_OK;
      granted    = 1'b0;
      slot       = 0;
      if (r.req_type == REQ_RETURN) begin
         // A return of a slot id never issued, into a class that does not
         // exist, or onto a full stack is refused and changes nothing.
         if (r.ret_class >= SIZE_COUNT) begin
            res.status = ST_BAD_RETURN;
         end else if (r.ret_slot >= fresh_count[r.ret_class] ||
                      stack_top[r.ret_class] >= SLOTS_PER_CLASS) begin
            res.status = ST_BAD_RETURN;
         end else begin
            free_slots[r.ret_class][stack_top[r.ret_class]] = r.ret_slot;
            stack_top[r.ret_class]++;
         end
      end else begin
         // Smallest class whose buffer holds the request; zero bytes is 4K.
         cls = SIZE_COUNT;
         for (int k = SIZE_COUNT - 1; k >= 0; k--)
            if (64'(r.request_bytes) <= 64'(CLASS_KB[k]) * 1024) cls = k;
         if (cls == SIZE_COUNT) begin
            res.status = ST_TOO_LARGE;
         end else begin
            usable_prealloc = (prealloc_cfg[cls] > SLOTS_PER_CLASS) ?
                              SLOTS_PER_CLASS : prealloc_cfg[cls];
            if (stack_top[cls] > 0) begin
               stack_top[cls]--;
               slot    = free_slots[cls][stack_top[cls]];
               granted = 1'b1;
            end else if (fresh_count[cls] < usable_prealloc) begin
               slot    = fresh_count[cls]++;
               granted = 1'b1;
            end else if (booked_kb() + CLASS_KB[cls] >= 64'(limit_kb)) begin
               // The budget is tested before the slot id supply.
               res.status = ST_BUDGET;
            end else if (fresh_count[cls] >= SLOTS_PER_CLASS) begin
               res.status = ST_NO_SLOT;
            end else begin
               extra_kb += CLASS_KB[cls];
               slot      = fresh_count[cls]++;
               granted   = 1'b1;
            end
            if (granted) begin
               res.size_class = cls[CLASS_W-1:0];
               res.slot_id    = slot[SLOT_W-1:0];
            end
         end
      end
      return res;
   endfunction

   // Fields that a request kind does not use carry random values, so the
   // block is also checked for ignoring them.
   function automatic req_item_type alloc_request(input logic [BYTES_W-1:0] bytes);
      req_item_type r;
      r.req_type      = REQ_ALLOC;
      r.request_bytes = bytes;
      r.ret_class     = CLASS_W'($urandom);
      r.ret_slot      = SLOT_W'($urandom);
      return r;
   endfunction

   function automatic req_item_type return_request(input logic [CLASS_W-1:0] cls,
                                                   input logic [SLOT_W-1:0] slot);
      req_item_type r;
      r.req_type      = REQ_RETURN;
      r.request_bytes = BYTES_W'($urandom);
      r.ret_class     = cls;
      r.ret_slot      = slot;
      return r;
   endfunction

   // Mostly sized allocations and returns of buffers really granted, with
   // some oversize requests and returns of arbitrary class and slot.
   function automatic req_item_type random_request();
      req_item_type r;
      buffer_ref_type b;
      int unsigned pick;
      int unsigned c;
      int unsigned top;
      int unsigned bottom;
      int idx;
      pick = $urandom_range(99);
      if (pick < 35 && outstanding_buffers.size() != 0) begin
         idx = $urandom_range(outstanding_buffers.size() - 1);
         b   = outstanding_buffers[idx];
         outstanding_buffers.delete(idx);
         r = return_request(b.cls, b.slot);
      end else if (pick < 45) begin
         r = return_request(CLASS_W'($urandom), SLOT_W'($urandom));
      end else if (pick < 50) begin
         r = alloc_request(BYTES_W'($urandom_range(32'h7FFF_FFFF, 32'd8388609)));
      end else begin
         c   = $urandom_range(SIZE_COUNT - 1);
         top = CLASS_KB[c] * 1024;
         if (c == 0) bottom = 0;
         else bottom = CLASS_KB[c - 1] * 1024 + 1;
         case ($urandom_range(9))
            0: r = alloc_request(BYTES_W'(top));
            1: r = alloc_request(BYTES_W'(bottom));
            2: r = alloc_request('0);
            default: r = alloc_request(BYTES_W'($urandom_range(top, bottom)));
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      // Only the first hundred are printed; the rest are just counted.
      if (error_count <= 100) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // APB write: setup cycle, then access cycle. The register takes the value
   // at the edge where psel, penable and pwrite are high. Only used while the
   // block is idle, so the shadow copy is updated right away.
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_MEM_LIMIT) limit_kb = value;
      else prealloc_cfg[idx - REG_PREALLOC_4K] = value[PRE_W-1:0];
      @(negedge clock);
   endtask

   task automatic apply_setup(input logic [LIMIT_W-1:0] limit, input prealloc_vec_type pre);
      csr_write(REG_MEM_LIMIT, limit);
      for (int k = 0; k < SIZE_COUNT; k++)
         csr_write(reg_index_type'(REG_PREALLOC_4K + k), 32'(pre[k]));
   endtask

   // Keeps only a few requests queued ahead of the driver, so that returns
   // refer to buffers whose grants have already been seen.
   task automatic offer(input req_item_type r);
      while (pending_requests.size() >= 4) @(negedge clock);
      pending_requests.push_back(r);
   endtask

   // Returns once everything offered has been accepted and answered.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || push || awaited_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) offer(random_request());
   endtask

   // ---------------------------------------------------------------------
   // Request driver. A transaction is taken at an edge with push high and
   // full low; that is where its result is predicted. A new request is put
   // up only once the previous one is gone, unless the sender idles.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full)
            awaited_results.push_back({req_data.req_type == REQ_ALLOC,
                                       serve_request(req_data)});
         if (!push || !full) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_requests.pop_front();
               push     <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor. Each result transaction is compared with the oldest
   // prediction, field by field. Granted buffers are remembered so that the
   // stimulus can return them later.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result %0d with nothing awaited: status %0d class %0d slot %0d",
                                         results_seen, rsp_data.status, rsp_data.size_class,
                                         rsp_data.slot_id));
            end else begin
               head = awaited_results.pop_front();
               if (rsp_data.status !== head.rsp.status)
                  report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                            results_seen, rsp_data.status, head.rsp.status));
               if (rsp_data.size_class !== head.rsp.size_class)
                  report_mismatch($sformatf("result %0d size_class %0d, expected %0d",
                                            results_seen, rsp_data.size_class,
                                            head.rsp.size_class));
               if (rsp_data.slot_id !== head.rsp.slot_id)
                  report_mismatch($sformatf("result %0d slot_id %0d, expected %0d",
                                            results_seen, rsp_data.slot_id, head.rsp.slot_id));
               if (head.from_alloc && head.rsp.status == ST_OK)
                  outstanding_buffers.push_back({head.rsp.size_class, head.rsp.slot_id});
            end
         end
         pop <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // The receiver's long hold-off runs down here, one per cycle.
   always @(posedge clock) begin
      if (rx_hold_left > 0) rx_hold_left <= rx_hold_left - 1;
   end

   // Watchdog: too long without a transaction on either side means a hang.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence. Registers are only written between phases, once every
   // predicted result has arrived.
   // ---------------------------------------------------------------------
   initial begin
      prealloc_vec_type pre;

      // Shadow state at reset: register defaults, empty stacks, nothing
      // handed out, nothing charged.
      limit_kb = MEM_LIMIT_RESET;
      for (int k = 0; k < SIZE_COUNT; k++) begin
         prealloc_cfg[k] = PREALLOC_RESET[k];
         stack_top[k]    = 0;
         fresh_count[k]  = 0;
      end
      extra_kb = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests on the reset configuration, with no idling.
      // Class boundaries on both sides, zero bytes, oversize requests,
      // LIFO reuse of returned slots and the kinds of bad return.
      offer(alloc_request(0));
      offer(alloc_request(4096));
      offer(alloc_request(4097));
      offer(alloc_request(16384));
      offer(alloc_request(65536));
      offer(alloc_request(262144));
      offer(alloc_request(1048576));
      offer(alloc_request(4194304));
      offer(alloc_request(8388608));
      offer(alloc_request(8388609));
      offer(alloc_request(31'h7FFF_FFFF));
      offer(return_request(0, 1));
      offer(return_request(0, 0));
      offer(alloc_request(100));
      offer(alloc_request(100));
      offer(return_request(3'h7, 0));
      offer(return_request(0, 13'h1FFF));
      offer(return_request(3, 1));
      // The same 8M buffer handed back twice is taken both times.
      offer(return_request(6, 0));
      offer(return_request(6, 0));
      offer(alloc_request(8388608));
      offer(alloc_request(8388608));
      offer(alloc_request(1));
      wait_drained();

      // Class 0 with preallocation above the slot supply and an unlimited
      // budget: take a run of 4K buffers, then hand back a mix of issued
      // and never issued slot ids.
      pre    = PREALLOC_RESET;
      pre[0] = 14'h3FFF;
      apply_setup(32'hFFFF_FFFF, pre);
      repeat (30) offer(alloc_request(BYTES_W'($urandom_range(4096))));
      wait_drained();
      repeat (30)
         offer(return_request(3'd0, SLOT_W'($urandom_range(fresh_count[0] + 7))));
      wait_drained();
      outstanding_buffers.delete();

      // Budget edge: room for exactly one more 16K buffer. The next one
      // would land on the limit itself and is refused.
      pre    = '0;
      pre[0] = 14'h3FFF;
      apply_setup(32'hFFFF_FFFF, pre);
      csr_write(REG_MEM_LIMIT, 32'(booked_kb() + 2 * CLASS_KB[1]));
      offer(alloc_request(16384));
      offer(alloc_request(16384));
      offer(alloc_request(8388608));
      offer(alloc_request(1));
      wait_drained();

      // Tight budget, few preallocated slots; the sender idles most cycles.
      pre = {14'd0, 14'd0, 14'd1, 14'd0, 14'd1, 14'd2, 14'd8192};
      apply_setup(32'hFFFF_FFFF, pre);
      csr_write(REG_MEM_LIMIT, 32'(booked_kb() + $urandom_range(60000, 20000)));
      send_idle_pct  = 87;
      recv_stall_pct = 0;
      run_random(440);
      wait_drained();

      // Zero budget: only stacks and preallocation can serve. The receiver
      // stalls most cycles.
      for (int k = 0; k < SIZE_COUNT; k++) pre[k] = PRE_W'($urandom_range(16383));
      pre[3] = 14'd8192;
      pre[5] = 14'd0;
      apply_setup(32'h0000_0000, pre);
      send_idle_pct  = 0;
      recv_stall_pct = 87;
      run_random(440);
      wait_drained();

      // No preallocation and an unlimited budget, so every new buffer is an
      // extra one. Both sides idle a little, and the receiver first holds
      // off for a long stretch while requests keep coming, so the result
      // and command queues fill and full rises.
      apply_setup(32'hFFFF_FFFF, '0);
      send_idle_pct  = 7;
      recv_stall_pct = 7;
      rx_hold_left   = HOLD_OFF_CYCLES;
      run_random(440);
      wait_drained();

      // Random budget and small preallocations at full rate. Halfway the
      // sender waits until every result is back before going on.
      for (int k = 0; k < SIZE_COUNT; k++) pre[k] = PRE_W'($urandom_range(40));
      apply_setup($urandom, pre);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(220);
      wait_drained();
      run_random(220);
      wait_drained();

      // Nothing should come out after the last predicted result.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/core/scbp_pkg.sv
rtl/core/scbp_csr.sv
rtl/core/scbp_front.sv
rtl/core/scbp_back.sv
rtl/core/size_class_buffer_pool.sv
tb/tb_size_class_buffer_pool.sv
